>>> hw/rtl/mecd_pkg.sv
// Shared types, codes and constants for the multi-encoding code point decoder.
// No dependencies; every other file refers to this package by scoped names.
package mecd_pkg;

    // Encoding selections held in the mode register
    localparam logic [2:0] MODE_UTF8     = 3'd0;
    localparam logic [2:0] MODE_UTF16_LE = 3'd1;
    localparam logic [2:0] MODE_UTF16_BE = 3'd2;
    localparam logic [2:0] MODE_UTF32_LE = 3'd3;
    localparam logic [2:0] MODE_UTF32_BE = 3'd4;
    localparam logic [2:0] MODE_WIN1252  = 3'd5;

    // Configuration register indexes (byte address / 4)
    localparam logic REG_ENCODING_MODE = 1'b0;

    // Code point constants
    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [31:0] CP_MAX         = 32'h0010FFFF;
    localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;

    // Minimum-value classes for the range check in the back end
    localparam logic [1:0] MIN_NONE  = 2'd0;
    localparam logic [1:0] MIN_TWO   = 2'd1;
    localparam logic [1:0] MIN_THREE = 2'd2;
    localparam logic [1:0] MIN_FOUR  = 2'd3;

    // Queue between front and back end
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    // What the back end has to do with a queued transaction
    typedef enum logic [2:0] {
        KIND_DIRECT,    // value is the code point
        KIND_REPL,      // error: emit the replacement character
        KIND_CHECK,     // range, surrogate and overlong check on value
        KIND_PAIR,      // combine surrogate pair bits held in value[19:0]
        KIND_WIN1252    // table lookup on value[4:0]
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [1:0]  min_class;
    } rec_t;

    // Configuration to the front end
    typedef struct packed {
        logic [2:0] mode;
        logic       clear;
    } cfg_ctrl_t;

    // Windows-1252 mapping for bytes 0x80 to 0x9F
    function automatic logic [15:0] win1252_hi(input logic [4:0] idx);
        logic [15:0] cp;
        case (idx)
            5'd0:  cp = 16'h20AC;
            5'd1:  cp = 16'h0081;
            5'd2:  cp = 16'h201A;
            5'd3:  cp = 16'h0192;
            5'd4:  cp = 16'h201E;
            5'd5:  cp = 16'h2026;
            5'd6:  cp = 16'h2020;
            5'd7:  cp = 16'h2021;
            5'd8:  cp = 16'h02C6;
            5'd9:  cp = 16'h2030;
            5'd10: cp = 16'h0160;
            5'd11: cp = 16'h2039;
            5'd12: cp = 16'h0152;
            5'd13: cp = 16'h008D;
            5'd14: cp = 16'h017D;
            5'd15: cp = 16'h008F;
            5'd16: cp = 16'h0090;
            5'd17: cp = 16'h2018;
            5'd18: cp = 16'h2019;
            5'd19: cp = 16'h201C;
            5'd20: cp = 16'h201D;
            5'd21: cp = 16'h2022;
            5'd22: cp = 16'h2013;
            5'd23: cp = 16'h2014;
            5'd24: cp = 16'h02DC;
            5'd25: cp = 16'h2122;
            5'd26: cp = 16'h0161;
            5'd27: cp = 16'h203A;
            5'd28: cp = 16'h0153;
            5'd29: cp = 16'h009D;
            5'd30: cp = 16'h017E;
            default: cp = 16'h0178;
        endcase
        return cp;
    endfunction

endpackage

>>> hw/rtl/mecd_cfg.sv
// APB-style configuration port holding the encoding mode register.
// Depends on mecd_pkg for register indexes and the control struct.
module mecd_cfg
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output mecd_pkg::cfg_ctrl_t   ctrl
);

    logic       mode_hit;
    logic       mode_wr;
    logic [2:0] mode_reg;
    logic [2:0] mode_next;

    // Byte offset bits are ignored; paddr[2] selects the register
    assign mode_hit  = (paddr[2] == mecd_pkg::REG_ENCODING_MODE);
    assign pready    = 1'b1;
    assign mode_wr   = psel && penable && pwrite && pready && mode_hit;
    assign mode_next = mode_wr ? pwdata[2:0] : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mecd_pkg::MODE_UTF8;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Read back
    assign prdata = mode_hit ? {29'd0, mode_reg} : 32'd0;

    // A mode write wipes any partly decoded sequence
    assign ctrl.mode  = mode_reg;
    assign ctrl.clear = mode_wr;

endmodule

>>> hw/rtl/mecd_front.sv
// Front end: accepts bytes, gathers units and sequences, classifies them into
// queue transactions for the back end. Depends on mecd_pkg.
module mecd_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mecd_pkg::cfg_ctrl_t   ctrl,
    input  logic                  accept,
    input  logic                  cmd,
    input  logic [7:0]            data_byte,
    output logic                  rec_push,
    output mecd_pkg::rec_t        rec
);

    logic [31:0] unit_bytes_reg, unit_bytes_next;
    logic [1:0]  unit_cnt_reg, unit_cnt_next;
    logic [9:0]  high_sur_reg, high_sur_next;
    logic        have_high_reg, have_high_next;
    logic [20:0] acc_reg, acc_next;
    logic [1:0]  remain_reg, remain_next;
    logic [1:0]  len_class_reg, len_class_next;

    logic [15:0] unit16;
    logic [20:0] acc_shift;
    logic [1:0]  remain_dec;
    logic [31:0] u32_le;
    logic [31:0] u32_be;

    // Datapath helpers
    assign unit16     = (ctrl.mode == mecd_pkg::MODE_UTF16_LE)
                        ? {data_byte, unit_bytes_reg[7:0]}
                        : {unit_bytes_reg[7:0], data_byte};
    assign acc_shift  = {acc_reg[14:0], data_byte[5:0]};
    assign remain_dec = remain_reg - 2'd1;
    assign u32_be     = {unit_bytes_reg[23:0], data_byte};

    always_comb
    begin
        u32_le = unit_bytes_reg;
        u32_le[{unit_cnt_reg, 3'b000} +: 8] = data_byte;
    end

    // Decode state update and classification
    always_comb
    begin
        unit_bytes_next = unit_bytes_reg;
        unit_cnt_next   = unit_cnt_reg;
        high_sur_next   = high_sur_reg;
        have_high_next  = have_high_reg;
        acc_next        = acc_reg;
        remain_next     = remain_reg;
        len_class_next  = len_class_reg;
        rec_push        = 1'b0;
        rec.kind        = mecd_pkg::KIND_DIRECT;
        rec.value       = {24'd0, data_byte};
        rec.min_class   = mecd_pkg::MIN_NONE;

        if (ctrl.clear || (accept && cmd))
        begin
            unit_bytes_next = '0;
            unit_cnt_next   = '0;
            high_sur_next   = '0;
            have_high_next  = 1'b0;
            acc_next        = '0;
            remain_next     = '0;
            len_class_next  = '0;
            // flush of an unfinished sequence or dangling high surrogate
            if (!ctrl.clear &&
                (((ctrl.mode == mecd_pkg::MODE_UTF8) && (remain_reg != 2'd0)) ||
                 (((ctrl.mode == mecd_pkg::MODE_UTF16_LE) ||
                   (ctrl.mode == mecd_pkg::MODE_UTF16_BE)) && have_high_reg)))
            begin
                rec_push = 1'b1;
                rec.kind = mecd_pkg::KIND_REPL;
            end
        end
        else if (accept)
        begin
            case (ctrl.mode)
                mecd_pkg::MODE_UTF8:
                begin
                    if (remain_reg == 2'd0)
                    begin
                        if (data_byte inside {[8'h00:8'h7F]})
                        begin
                            rec_push = 1'b1;
                        end
                        else if (data_byte inside {[8'hC2:8'hDF]})
                        begin
                            acc_next       = {16'd0, data_byte[4:0]};
                            len_class_next = mecd_pkg::MIN_TWO;
                            remain_next    = 2'd1;
                        end
                        else if (data_byte inside {[8'hE0:8'hEF]})
                        begin
                            acc_next       = {17'd0, data_byte[3:0]};
                            len_class_next = mecd_pkg::MIN_THREE;
                            remain_next    = 2'd2;
                        end
                        else if (data_byte inside {[8'hF0:8'hF4]})
                        begin
                            acc_next       = {18'd0, data_byte[2:0]};
                            len_class_next = mecd_pkg::MIN_FOUR;
                            remain_next    = 2'd3;
                        end
                        else
                        begin
                            rec_push = 1'b1;
                            rec.kind = mecd_pkg::KIND_REPL;
                        end
                    end
                    else if (data_byte[7:6] != 2'b10)
                    begin
                        // bad continuation: abandon the sequence
                        acc_next       = '0;
                        remain_next    = '0;
                        len_class_next = '0;
                        rec_push       = 1'b1;
                        rec.kind       = mecd_pkg::KIND_REPL;
                    end
                    else if (remain_dec != 2'd0)
                    begin
                        acc_next    = acc_shift;
                        remain_next = remain_dec;
                    end
                    else
                    begin
                        acc_next       = '0;
                        remain_next    = '0;
                        len_class_next = '0;
                        rec_push       = 1'b1;
                        rec.kind       = mecd_pkg::KIND_CHECK;
                        rec.value      = {11'd0, acc_shift};
                        rec.min_class  = len_class_reg;
                    end
                end

                mecd_pkg::MODE_UTF16_LE, mecd_pkg::MODE_UTF16_BE:
                begin
                    if (unit_cnt_reg == 2'd0)
                    begin
                        unit_bytes_next = {24'd0, data_byte};
                        unit_cnt_next   = 2'd1;
                    end
                    else
                    begin
                        unit_bytes_next = '0;
                        unit_cnt_next   = '0;
                        if (have_high_reg)
                        begin
                            have_high_next = 1'b0;
                            high_sur_next  = '0;
                            rec_push       = 1'b1;
                            if (unit16 inside {[16'hDC00:16'hDFFF]})
                            begin
                                rec.kind  = mecd_pkg::KIND_PAIR;
                                rec.value = {12'd0, high_sur_reg, unit16[9:0]};
                            end
                            else
                            begin
                                rec.kind = mecd_pkg::KIND_REPL;
                            end
                        end
                        else if (unit16 inside {[16'hD800:16'hDBFF]})
                        begin
                            high_sur_next  = unit16[9:0];
                            have_high_next = 1'b1;
                        end
                        else if (unit16 inside {[16'hDC00:16'hDFFF]})
                        begin
                            rec_push = 1'b1;
                            rec.kind = mecd_pkg::KIND_REPL;
                        end
                        else
                        begin
                            rec_push  = 1'b1;
                            rec.value = {16'd0, unit16};
                        end
                    end
                end

                mecd_pkg::MODE_UTF32_LE, mecd_pkg::MODE_UTF32_BE:
                begin
                    if (unit_cnt_reg != 2'd3)
                    begin
                        unit_bytes_next = (ctrl.mode == mecd_pkg::MODE_UTF32_LE)
                                          ? u32_le : u32_be;
                        unit_cnt_next   = unit_cnt_reg + 2'd1;
                    end
                    else
                    begin
                        unit_bytes_next = '0;
                        unit_cnt_next   = '0;
                        rec_push        = 1'b1;
                        rec.kind        = mecd_pkg::KIND_CHECK;
                        rec.value       = (ctrl.mode == mecd_pkg::MODE_UTF32_LE)
                                          ? u32_le : u32_be;
                    end
                end

                default:
                begin
                    // Windows-1252, also used for the spare mode codes
                    rec_push = 1'b1;
                    if (data_byte inside {[8'h80:8'h9F]})
                    begin
                        rec.kind = mecd_pkg::KIND_WIN1252;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_bytes_reg <= '0;
            unit_cnt_reg   <= '0;
            high_sur_reg   <= '0;
            have_high_reg  <= 1'b0;
            acc_reg        <= '0;
            remain_reg     <= '0;
            len_class_reg  <= '0;
        end
        else
        begin
            unit_bytes_reg <= unit_bytes_next;
            unit_cnt_reg   <= unit_cnt_next;
            high_sur_reg   <= high_sur_next;
            have_high_reg  <= have_high_next;
            acc_reg        <= acc_next;
            remain_reg     <= remain_next;
            len_class_reg  <= len_class_next;
        end
    end

    // A UTF-8 sequence never expects more continuation bytes than its lead set
    a_remain_le_class: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= len_class_reg)
        else $error("utf8 remaining count exceeds sequence length");

endmodule

>>> hw/rtl/mecd_fifo.sv
// Short flop-based queue of classified transactions between front and back.
// Depends on mecd_pkg for the record type and depth.
module mecd_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  mecd_pkg::rec_t    wr_data,
    input  logic              rd_en,
    output mecd_pkg::rec_t    rd_data,
    output logic              not_empty,
    output logic              is_full
);

    localparam logic [mecd_pkg::FIFO_AW:0] DEPTH_CNT =
        (mecd_pkg::FIFO_AW + 1)'(mecd_pkg::FIFO_DEPTH);

    mecd_pkg::rec_t               mem_reg [mecd_pkg::FIFO_DEPTH];
    logic [mecd_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mecd_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mecd_pkg::FIFO_AW:0]   count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign is_full   = (count_reg == DEPTH_CNT);
    assign rd_data   = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && is_full && !rd_en))
        else $error("transaction queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && !not_empty))
        else $error("transaction queue underflow");

endmodule

>>> hw/rtl/mecd_back.sv
// Back end: range checks, surrogate pairing and table lookup, then the result
// register that faces the consumer. Depends on mecd_pkg.
module mecd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  mecd_pkg::rec_t    head,
    input  logic              head_valid,
    output logic              head_take,
    input  logic              pop,
    output logic              empty,
    output logic [20:0]       code_point,
    output logic              replaced
);

    logic        out_valid_reg, out_valid_next;
    logic [20:0] cp_reg, cp_next;
    logic        repl_reg, repl_next;
    logic [31:0] min_val;
    logic        bad;

    // Result register is free, or is being emptied this cycle
    assign head_take = head_valid && (!out_valid_reg || pop);

    always_comb
    begin
        case (head.min_class)
            mecd_pkg::MIN_TWO:   min_val = 32'h0000_0080;
            mecd_pkg::MIN_THREE: min_val = 32'h0000_0800;
            mecd_pkg::MIN_FOUR:  min_val = 32'h0001_0000;
            default:             min_val = 32'h0000_0000;
        endcase
    end

    assign bad = (head.value < min_val) || (head.value > mecd_pkg::CP_MAX) ||
                 (head.value inside {[32'hD800:32'hDFFF]});

    // Final code point for the queued transaction
    always_comb
    begin
        cp_next   = head.value[20:0];
        repl_next = 1'b0;
        case (head.kind)
            mecd_pkg::KIND_DIRECT:
            begin
                cp_next = head.value[20:0];
            end
            mecd_pkg::KIND_REPL:
            begin
                cp_next   = mecd_pkg::CP_REPLACEMENT;
                repl_next = 1'b1;
            end
            mecd_pkg::KIND_CHECK:
            begin
                cp_next   = bad ? mecd_pkg::CP_REPLACEMENT : head.value[20:0];
                repl_next = bad;
            end
            mecd_pkg::KIND_PAIR:
            begin
                cp_next = mecd_pkg::CP_SUPP_BASE + {1'b0, head.value[19:0]};
            end
            mecd_pkg::KIND_WIN1252:
            begin
                cp_next = {5'd0, mecd_pkg::win1252_hi(head.value[4:0])};
            end
            default:
            begin
                cp_next   = mecd_pkg::CP_REPLACEMENT;
                repl_next = 1'b1;
            end
        endcase
    end

    assign out_valid_next = head_take ? 1'b1 : (pop ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_take)
        begin
            cp_reg   <= cp_next;
            repl_reg <= repl_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign code_point = cp_reg;
    assign replaced   = repl_reg;

    // An error result always carries the replacement character
    a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && repl_reg) |-> (cp_reg == mecd_pkg::CP_REPLACEMENT))
        else $error("replaced result without U+FFFD");

    // Delivered code points are Unicode scalar values
    a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((cp_reg <= 21'h10FFFF) &&
                           !((cp_reg >= 21'h00D800) && (cp_reg <= 21'h00DFFF))))
        else $error("result is not a scalar value");

endmodule

>>> hw/rtl/multi_encoding_codepoint_decoder_top.sv
// A byte that completes a character is written to the queue at its accepting edge
// and moves to the result register once that register is free or being popped.
// Throughput: one byte per cycle while full is low; full rises only when the four-entry
// transaction queue is filled behind a consumer that does not pop.
// Reset (rst_n low, asynchronous) clears all decode state, empties the queue
// and the result register, and selects UTF-8. Top level: instantiates mecd_*.
module multi_encoding_codepoint_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input
    input  logic        push,
    output logic        full,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    // code point output
    output logic        empty,
    input  logic        pop,
    output logic [20:0] code_point,
    output logic        replaced
);

    mecd_pkg::cfg_ctrl_t ctrl;
    mecd_pkg::rec_t      rec;
    mecd_pkg::rec_t      head;
    logic                accept;
    logic                rec_push;
    logic                head_valid;
    logic                head_take;
    logic                q_full;

    assign full   = q_full;
    assign accept = push && !q_full;

    mecd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ctrl    (ctrl)
    );

    mecd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .accept    (accept),
        .cmd       (cmd),
        .data_byte (data_byte),
        .rec_push  (rec_push),
        .rec       (rec)
    );

    mecd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (rec_push),
        .wr_data   (rec),
        .rd_en     (head_take),
        .rd_data   (head),
        .not_empty (head_valid),
        .is_full   (q_full)
    );

    mecd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_take  (head_take),
        .pop        (pop),
        .empty      (empty),
        .code_point (code_point),
        .replaced   (replaced)
    );

endmodule

>>> test/multi_encoding_codepoint_decoder_top_tb.sv
// Self-checking testbench for multi_encoding_codepoint_decoder_top.
// Depends on mecd_pkg and the decoder RTL; holds its own byte-to-code-point decoder
// and compares every popped code point with it.
`timescale 1ns / 100ps

module multi_encoding_codepoint_decoder_top_tb;

    // Input item commands
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Mode values outside the named encodings; both decode as Windows-1252
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    // Register map: mode register, and the first index past the list
    localparam logic [2:0] MODE_ADDR  = {mecd_pkg::REG_ENCODING_MODE, 2'b00};
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 180;
    localparam int NUM_PHASES    = 10;

    // Upper half of Windows-1252, bytes 0x80 to 0x9F
    localparam logic [0:31][15:0] WIN1252_UPPER = {
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    typedef struct {
        logic [20:0] cp;
        logic        bad;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic        cmd;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [20:0] code_point;
    logic        replaced;

    // Decoder state mirrored here
    logic [2:0]  mode_q;
    logic [31:0] unit_acc;
    logic [1:0]  unit_cnt;
    logic [9:0]  hi_sur;
    logic        hi_pending;
    logic [20:0] u8_acc;
    logic [1:0]  u8_left;
    logic [1:0]  u8_class;

    point_t      pending_points[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int unsigned idle_pct = 31;

    multi_encoding_codepoint_decoder_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .empty      (empty),
        .pop        (pop),
        .code_point (code_point),
        .replaced   (replaced)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    //--------------------------------------------------------------------
    // Decoder model
    //--------------------------------------------------------------------

    function automatic void clear_decode_state();
        unit_acc   = '0;
        unit_cnt   = '0;
        hi_sur     = '0;
        hi_pending = 1'b0;
        u8_acc     = '0;
        u8_left    = '0;
        u8_class   = '0;
    endfunction

    function automatic bit in_surrogate_range(input logic [31:0] v);
        return v >= 32'hD800 && v <= 32'hDFFF;
    endfunction

    // Advances the state by one item; returns 1 when a code point comes out
    function automatic bit decode_item(input logic c, input logic [7:0] b,
                                       output logic [20:0] cp, output logic bad);
        bit          hit;
        logic [15:0] unit;
        logic [31:0] word;
        logic [20:0] lowest;
        hit = 1'b0;
        cp  = mecd_pkg::CP_REPLACEMENT;
        bad = 1'b1;
        if (c == CMD_FLUSH)
        begin
            // cut-off UTF-8 or lone high surrogate is reported; partial units vanish
            hit = (mode_q == mecd_pkg::MODE_UTF8 && u8_left != 0) ||
                  ((mode_q == mecd_pkg::MODE_UTF16_LE ||
                    mode_q == mecd_pkg::MODE_UTF16_BE) && hi_pending);
            clear_decode_state();
        end
        else
        begin
            case (mode_q)
                mecd_pkg::MODE_UTF8:
                begin
                    if (u8_left == 0)
                    begin
                        if (b < 8'h80)
                        begin
                            hit = 1'b1;
                            cp  = {13'd0, b};
                            bad = 1'b0;
                        end
                        else if (b >= 8'hC2 && b <= 8'hDF)
                        begin
                            u8_acc   = {16'd0, b[4:0]};
                            u8_class = 2'd1;
                            u8_left  = 2'd1;
                        end
                        else if (b >= 8'hE0 && b <= 8'hEF)
                        begin
                            u8_acc   = {17'd0, b[3:0]};
                            u8_class = 2'd2;
                            u8_left  = 2'd2;
                        end
                        else if (b >= 8'hF0 && b <= 8'hF4)
                        begin
                            u8_acc   = {18'd0, b[2:0]};
                            u8_class = 2'd3;
                            u8_left  = 2'd3;
                        end
                        else
                        begin
                            hit = 1'b1;
                        end
                    end
                    else if (b[7:6] != 2'b10)
                    begin
                        // broken continuation: byte is swallowed with the sequence
                        clear_decode_state();
                        hit = 1'b1;
                    end
                    else
                    begin
                        u8_acc  = {u8_acc[14:0], b[5:0]};
                        u8_left = u8_left - 2'd1;
                        if (u8_left == 0)
                        begin
                            lowest = (u8_class == 2'd1) ? 21'h80 :
                                     (u8_class == 2'd2) ? 21'h800 : 21'h10000;
                            hit = 1'b1;
                            if (!(u8_acc < lowest || u8_acc > mecd_pkg::CP_MAX ||
                                  in_surrogate_range({11'd0, u8_acc})))
                            begin
                                cp  = u8_acc;
                                bad = 1'b0;
                            end
                            clear_decode_state();
                        end
                    end
                end
                mecd_pkg::MODE_UTF16_LE, mecd_pkg::MODE_UTF16_BE:
                begin
                    if (unit_cnt == 0)
                    begin
                        unit_acc = {24'd0, b};
                        unit_cnt = 2'd1;
                    end
                    else
                    begin
                        unit = (mode_q == mecd_pkg::MODE_UTF16_LE) ? {b, unit_acc[7:0]} :
                                                                     {unit_acc[7:0], b};
                        unit_acc = '0;
                        unit_cnt = '0;
                        hit = 1'b1;
                        if (hi_pending)
                        begin
                            // anything but a low surrogate is eaten with the high one
                            if (unit[15:10] == 6'b110111)
                            begin
                                cp  = mecd_pkg::CP_SUPP_BASE + {1'b0, hi_sur, unit[9:0]};
                                bad = 1'b0;
                            end
                            hi_pending = 1'b0;
                            hi_sur     = '0;
                        end
                        else if (unit[15:10] == 6'b110110)
                        begin
                            hi_sur     = unit[9:0];
                            hi_pending = 1'b1;
                            hit        = 1'b0;
                        end
                        else if (unit[15:10] != 6'b110111)
                        begin
                            cp  = {5'd0, unit};
                            bad = 1'b0;
                        end
                    end
                end
                mecd_pkg::MODE_UTF32_LE, mecd_pkg::MODE_UTF32_BE:
                begin
                    if (mode_q == mecd_pkg::MODE_UTF32_LE)
                        unit_acc = unit_acc | ({24'd0, b} << (8 * unit_cnt));
                    else
                        unit_acc = {unit_acc[23:0], b};
                    if (unit_cnt < 2'd3)
                    begin
                        unit_cnt = unit_cnt + 2'd1;
                    end
                    else
                    begin
                        word     = unit_acc;
                        unit_acc = '0;
                        unit_cnt = '0;
                        hit      = 1'b1;
                        if (!(word > mecd_pkg::CP_MAX || in_surrogate_range(word)))
                        begin
                            cp  = word[20:0];
                            bad = 1'b0;
                        end
                    end
                end
                default:
                begin
                    hit = 1'b1;
                    bad = 1'b0;
                    if (b[7:5] == 3'b100)
                        cp = {5'd0, WIN1252_UPPER[b[4:0]]};
                    else
                        cp = {13'd0, b};
                end
            endcase
        end
        return hit;
    endfunction

    //--------------------------------------------------------------------
    // Byte sender and configuration port
    //--------------------------------------------------------------------

    // Every task below is entered and left just after a rising edge
    task automatic send_item(input logic c, input logic [7:0] b);
        logic [20:0] cp;
        logic        bad;
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        cmd       <= c;
        data_byte <= b;
        // full is stable from the falling edge to the accepting edge
        forever
        begin
            @(negedge clk);
            if (!full)
                break;
            @(posedge clk);
        end
        if (decode_item(c, b, cp, bad))
            pending_points.push_back('{cp, bad});
        items_sent++;
        @(posedge clk);
    endtask

    task automatic send_data(input logic [7:0] b);
        send_item(CMD_DATA, b);
    endtask

    task automatic send_flush();
        send_item(CMD_FLUSH, 8'($urandom_range(255)));
    endtask

    task automatic send_unit16(input bit little, input logic [15:0] u);
        if (little)
        begin
            send_data(u[7:0]);
            send_data(u[15:8]);
        end
        else
        begin
            send_data(u[15:8]);
            send_data(u[7:0]);
        end
    endtask

    task automatic send_word32(input bit little, input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            send_data(little ? w[8*i +: 8] : w[8*(3-i) +: 8]);
    endtask

    // Stop sending, let all results out, then allow the back end to settle
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (pready)
                break;
            @(posedge clk);
        end
        // any mode write restarts decoding; other indexes are ignored
        if (addr == MODE_ADDR)
        begin
            mode_q = value[2:0];
            clear_decode_state();
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (pready)
                break;
            @(posedge clk);
        end
        if (prdata !== want)
        begin
            $error("prdata: expected %h, got %h", want, prdata);
            fail_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Mode write with junk in the upper data bits, then read back
    task automatic set_mode(input logic [2:0] mode);
        logic [31:0] value;
        value      = $urandom();
        value[2:0] = mode;
        apb_write(MODE_ADDR, value);
        apb_read_check(MODE_ADDR, {29'd0, mode});
    endtask

    //--------------------------------------------------------------------
    // Random traffic per encoding
    //--------------------------------------------------------------------

    task automatic send_utf8_chunk();
        int          r;
        int          len;
        logic [7:0]  lead;
        r = $urandom_range(99);
        if (r < 3)
        begin
            send_flush();
        end
        else if (r < 28)
        begin
            send_data(8'($urandom_range(8'h7F)));
        end
        else if (r < 88)
        begin
            // well-formed shape, random payload: overlong, surrogate and
            // out-of-range forms come out of this on their own
            len = $urandom_range(3, 1);
            case (len)
                1:       lead = 8'($urandom_range(8'hDF, 8'hC2));
                2:       lead = 8'($urandom_range(8'hEF, 8'hE0));
                default: lead = 8'($urandom_range(8'hF4, 8'hF0));
            endcase
            send_data(lead);
            repeat (len) send_data(8'h80 | 8'($urandom_range(63)));
        end
        else if (r < 95)
        begin
            send_data(8'($urandom_range(255)));
        end
        else
        begin
            // cut-off sequence ended by a flush or a stray byte
            send_data(8'($urandom_range(8'hF4, 8'hE0)));
            repeat ($urandom_range(1)) send_data(8'h80 | 8'($urandom_range(63)));
            if ($urandom_range(1))
                send_flush();
            else
                send_data(8'($urandom_range(255)));
        end
    endtask

    task automatic send_utf16_chunk(input bit little);
        int r;
        r = $urandom_range(99);
        if (r < 5)
            send_flush();
        else if (r < 55)
            send_unit16(little, 16'($urandom_range(16'hFFFF)));
        else if (r < 80)
        begin
            send_unit16(little, 16'($urandom_range(16'hDBFF, 16'hD800)));
            send_unit16(little, 16'($urandom_range(16'hDFFF, 16'hDC00)));
        end
        else if (r < 87)
            send_unit16(little, 16'($urandom_range(16'hDFFF, 16'hDC00)));
        else if (r < 95)
        begin
            send_unit16(little, 16'($urandom_range(16'hDBFF, 16'hD800)));
            send_unit16(little, 16'($urandom_range(16'hFFFF)));
        end
        else
            send_data(8'($urandom_range(255)));
    endtask

    task automatic send_utf32_chunk(input bit little);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            send_flush();
        else if (r < 60)
            send_word32(little, 32'($urandom_range(32'h10FFFF)));
        else if (r < 70)
            send_word32(little, 32'($urandom_range(32'hDFFF, 32'hD800)));
        else if (r < 80)
            send_word32(little, $urandom());
        else if (r < 92)
            send_word32(little, 32'($urandom_range(32'hFFFF)));
        else
            send_data(8'($urandom_range(255)));
    endtask

    task automatic send_random_chunk(input logic [2:0] mode);
        case (mode)
            mecd_pkg::MODE_UTF8:     send_utf8_chunk();
            mecd_pkg::MODE_UTF16_LE: send_utf16_chunk(1'b1);
            mecd_pkg::MODE_UTF16_BE: send_utf16_chunk(1'b0);
            mecd_pkg::MODE_UTF32_LE: send_utf32_chunk(1'b1);
            mecd_pkg::MODE_UTF32_BE: send_utf32_chunk(1'b0);
            default:
            begin
                if ($urandom_range(99) < 3)
                    send_flush();
                else
                    send_data(8'($urandom_range(255)));
            end
        endcase
    endtask

    //--------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------

    task automatic test_utf8_cases();
        set_mode(mecd_pkg::MODE_UTF8);
        send_data(8'h00);
        send_data(8'hFF);                   // bad lead
        send_data(8'hC3);                   // lead, then a non-continuation
        send_data(8'h41);
        send_data(8'hF4);                   // U+10FFFF, the top
        send_data(8'h8F);
        send_data(8'hBF);
        send_data(8'hBF);
        send_data(8'hED);                   // encoded surrogate
        send_data(8'hA0);
        send_data(8'h80);
        send_data(8'hEF);                   // genuine U+FFFD, not flagged
        send_data(8'hBF);
        send_data(8'hBD);
        send_data(8'hE2);                   // cut off by end of stream
        send_flush();
        send_flush();                       // nothing pending
        wait_drained();
    endtask

    task automatic test_utf16_cases();
        set_mode(mecd_pkg::MODE_UTF16_LE);
        send_unit16(1'b1, 16'hD83D);        // surrogate pair
        send_unit16(1'b1, 16'hDE00);
        send_unit16(1'b1, 16'hDC00);        // lone low surrogate
        wait_drained();
        set_mode(mecd_pkg::MODE_UTF16_BE);
        send_unit16(1'b0, 16'hD800);        // high followed by a plain unit
        send_unit16(1'b0, 16'h0041);
        send_unit16(1'b0, 16'hDBFF);        // high left dangling at end of stream
        send_flush();
        wait_drained();
    endtask

    task automatic test_utf32_cases();
        set_mode(mecd_pkg::MODE_UTF32_LE);
        send_word32(1'b1, 32'h0010FFFF);
        send_data(8'hFF);                   // partial unit dropped on flush
        send_flush();
        wait_drained();
        set_mode(mecd_pkg::MODE_UTF32_BE);
        send_word32(1'b0, 32'h00110000);    // above the top
        send_word32(1'b0, 32'h0000DFFF);    // surrogate
        wait_drained();
    endtask

    task automatic test_win1252_cases();
        set_mode(mecd_pkg::MODE_WIN1252);
        send_data(8'h80);
        send_data(8'h9F);
        send_data(8'hFF);
        wait_drained();
        set_mode(MODE_SPARE6);
        send_data(8'h8C);
        wait_drained();
        set_mode(MODE_SPARE7);
        send_data(8'h9D);
        wait_drained();
    endtask

    // A mode write drops a half-decoded sequence; a write past the map does not
    task automatic test_mode_write_effects();
        set_mode(mecd_pkg::MODE_UTF8);
        send_data(8'hE2);
        wait_drained();
        apb_write(SPARE_ADDR, {29'd0, mecd_pkg::MODE_UTF16_BE});
        send_data(8'h82);
        send_data(8'hAC);
        send_data(8'hE2);
        wait_drained();
        set_mode(mecd_pkg::MODE_UTF8);
        send_data(8'h82);
        wait_drained();
    endtask

    task automatic test_random_streams();
        logic [2:0] mode;
        int         target;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 8)
                mode = 3'(p);
            else if (p == 8)
                mode = mecd_pkg::MODE_UTF8;
            else
                mode = mecd_pkg::MODE_WIN1252;
            // one phase runs flat out on both sides
            idle_pct = (p == 8) ? 0 : 31;
            set_mode(mode);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                send_random_chunk(mode);
                if ($urandom_range(59) == 0)
                    wait_drained();
            end
            wait_drained();
        end
        idle_pct = 31;
    endtask

    //--------------------------------------------------------------------
    // Result side
    //--------------------------------------------------------------------

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    // pop and empty are stable from the falling edge to the accepting edge
    always @(negedge clk)
    begin : check_point
        point_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_points.size() == 0)
            begin
                $error("code_point: none expected, got %h (replaced %b)",
                       code_point, replaced);
                fail_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (code_point !== want.cp)
                begin
                    $error("code_point: expected %h, got %h", want.cp, code_point);
                    fail_count++;
                end
                if (replaced !== want.bad)
                begin
                    $error("replaced: expected %b, got %b", want.bad, replaced);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on any port
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((push && !full) || (pop && !empty) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    //--------------------------------------------------------------------
    // Sequence
    //--------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        push      = 1'b0;
        cmd       = CMD_DATA;
        data_byte = '0;
        mode_q    = mecd_pkg::MODE_UTF8;
        clear_decode_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_utf8_cases();
        test_utf16_cases();
        test_utf32_cases();
        test_win1252_cases();
        test_mode_write_effects();
        test_random_streams();

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
